// ----- rtl/gmdl_pkg.sv -----
// Package for the grid max-distance-to-land block: constants and shared types.
// Used by gmdl_front, gmdl_back and grid_max_distance_to_land_top; no dependencies.
package gmdl_pkg;
    localparam int GRID_MAX_DEF = 128;
    localparam logic [7:0] DIST_NONE = 8'd255;
    localparam logic [7:0] CFG_ROWS = 8'd0;
    localparam logic [7:0] CFG_COLS = 8'd1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_BWD_RD,
        ST_BWD_WR,
        ST_OUT
    } t_back_state;

    function automatic logic [7:0] inc_sat(input logic [7:0] d);
        inc_sat = (d == DIST_NONE) ? DIST_NONE : d + 8'd1;
    endfunction
endpackage

// ----- rtl/gmdl_front.sv -----
// Front end: accepts cells, tracks the load position and tags each cell for the back end.
// Depends on gmdl_pkg.
module gmdl_front #(
    parameter int GRID_MAX = gmdl_pkg::GRID_MAX_DEF,
    localparam int PW = $clog2(GRID_MAX)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_restart,
    input  logic [PW:0]   i_rows,
    input  logic [PW:0]   i_cols,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_is_land,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [2*PW+1:0] o_item
);
    logic [PW-1:0] r_row, r_col, n_row, n_col;
    logic [PW-1:0] r_q_row [2];
    logic [PW-1:0] r_q_col [2];
    logic          r_q_land [2];
    logic          r_q_last [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          last_col, last_row, push, pop;

    assign o_ready  = (r_cnt != 2'd2) && !i_restart;
    assign push     = i_valid && o_ready;
    assign pop      = o_valid && i_ready;
    assign o_valid  = r_cnt != 2'd0;
    assign last_col = ({1'b0, r_col} + 1'b1) >= i_cols;
    assign last_row = ({1'b0, r_row} + 1'b1) >= i_rows;
    assign o_item   = {r_q_row[r_rp], r_q_col[r_rp], r_q_land[r_rp], r_q_last[r_rp]};

    // Advance raster position
    always_comb begin
        n_row = r_row;
        n_col = r_col + 1'b1;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_row <= '0;
            r_col <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_row <= n_row;
                r_col <= n_col;
                r_wp  <= ~r_wp;
            end
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    // Queue payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_row[r_wp]  <= r_row;
            r_q_col[r_wp]  <= r_col;
            r_q_land[r_wp] <= i_is_land;
            r_q_last[r_wp] <= last_col && last_row;
        end
    end
endmodule

// ----- rtl/gmdl_back.sv -----
// Back end: forward pass while cells arrive, then the backward pass and the max search.
// Depends on gmdl_pkg; holds the distance store.
module gmdl_back #(
    parameter int GRID_MAX = gmdl_pkg::GRID_MAX_DEF,
    localparam int PW = $clog2(GRID_MAX)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_restart,
    input  logic [PW:0]     i_rows,
    input  logic [PW:0]     i_cols,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [2*PW+1:0] i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_max_distance,
    output logic            o_no_answer
);
    logic [7:0] r_mem [2**(2*PW)];
    logic [7:0] r_lft, r_rgt;
    logic [7:0] r_rd_self, r_rd_up, r_rd_dn;
    gmdl_pkg::t_back_state r_st, n_st;
    logic [PW-1:0] r_br, r_bc, n_br, n_bc;
    logic [PW-1:0] it_row, it_col;
    logic          it_land, it_last;
    logic          r_land_seen, r_sea_seen;
    logic [7:0]    r_best;
    logic          r_pend, r_pend_last, r_pend_land;
    logic [PW-1:0] r_pend_row, r_pend_col;
    logic [7:0]    fwd_d, bwd_d, tmp;
    logic          take;

    assign {it_row, it_col, it_land, it_last} = i_item;
    assign o_ready = (r_st == gmdl_pkg::ST_LOAD) && !r_pend && !i_restart;
    assign take    = i_valid && o_ready;
    assign o_valid = r_st == gmdl_pkg::ST_OUT;
    assign o_no_answer    = !(r_land_seen && r_sea_seen);
    assign o_max_distance = o_no_answer ? 8'd0 : r_best;

    // Forward step for the pending cell: up from registered read, left from last result
    always_comb begin
        fwd_d = gmdl_pkg::DIST_NONE;
        if (r_pend_row != '0) fwd_d = gmdl_pkg::inc_sat(r_rd_up);
        if (r_pend_col != '0) begin
            tmp = gmdl_pkg::inc_sat(r_lft);
            if (tmp < fwd_d) fwd_d = tmp;
        end else begin
            tmp = 8'd0;
        end
        if (r_pend_land) fwd_d = 8'd0;
    end

    // Backward step: down from the registered store read, right from last result
    always_comb begin
        bwd_d = r_rd_self;
        if (bwd_d != 8'd0) begin
            if (({1'b0, r_br} + 1'b1) < i_rows && gmdl_pkg::inc_sat(r_rd_dn) < bwd_d)
                bwd_d = gmdl_pkg::inc_sat(r_rd_dn);
            if (({1'b0, r_bc} + 1'b1) < i_cols && gmdl_pkg::inc_sat(r_rgt) < bwd_d)
                bwd_d = gmdl_pkg::inc_sat(r_rgt);
        end
    end

    // Next state and backward scan position
    always_comb begin
        n_st = r_st;
        n_br = r_br;
        n_bc = r_bc;
        case (r_st)
            gmdl_pkg::ST_LOAD: begin
                if (r_pend && r_pend_last) begin
                    n_st = gmdl_pkg::ST_BWD_RD;
                    n_br = r_pend_row;
                    n_bc = r_pend_col;
                end
            end
            gmdl_pkg::ST_BWD_RD: n_st = gmdl_pkg::ST_BWD_WR;
            gmdl_pkg::ST_BWD_WR: begin
                n_st = gmdl_pkg::ST_BWD_RD;
                if (r_bc != '0) begin
                    n_bc = r_bc - 1'b1;
                end else if (r_br != '0) begin
                    n_br = r_br - 1'b1;
                    n_bc = PW'(i_cols - 1'b1);
                end else begin
                    n_st = gmdl_pkg::ST_OUT;
                end
            end
            gmdl_pkg::ST_OUT: if (i_ready) n_st = gmdl_pkg::ST_LOAD;
            default: n_st = gmdl_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_st        <= gmdl_pkg::ST_LOAD;
            r_pend      <= 1'b0;
            r_land_seen <= 1'b0;
            r_sea_seen  <= 1'b0;
            r_best      <= 8'd0;
        end else begin
            r_st   <= n_st;
            r_pend <= take;
            if (take) begin
                if (it_land) r_land_seen <= 1'b1;
                else         r_sea_seen  <= 1'b1;
            end
            if (r_st == gmdl_pkg::ST_BWD_WR && bwd_d > r_best) r_best <= bwd_d;
            if (r_st == gmdl_pkg::ST_OUT && i_ready) begin
                r_land_seen <= 1'b0;
                r_sea_seen  <= 1'b0;
                r_best      <= 8'd0;
            end
        end
    end

    // Payload and store access
    always_ff @(posedge i_clk) begin
        r_br <= n_br;
        r_bc <= n_bc;
        if (take) begin
            r_pend_row  <= it_row;
            r_pend_col  <= it_col;
            r_pend_land <= it_land;
            r_pend_last <= it_last;
            r_rd_up     <= r_mem[{it_row - 1'b1, it_col}];
        end
        if (r_pend) begin
            r_mem[{r_pend_row, r_pend_col}] <= fwd_d;
            r_lft <= fwd_d;
        end
        if (r_st == gmdl_pkg::ST_BWD_RD) begin
            r_rd_self <= r_mem[{r_br, r_bc}];
            r_rd_dn   <= r_mem[{r_br + 1'b1, r_bc}];
        end
        if (r_st == gmdl_pkg::ST_BWD_WR) begin
            r_mem[{r_br, r_bc}] <= bwd_d;
            r_rgt <= bwd_d;
        end
    end
endmodule

// ----- rtl/grid_max_distance_to_land_top.sv -----
// Grid max distance to land. The back end takes no new cell while the last one is still
// pending (store write of one cell, then the up-neighbor read of the next), and a
// two-entry queue lets the front keep accepting meanwhile. After the last cell transfer,
// once the back end has caught up, it runs the backward pass, a read state and a write
// state per cell, then holds the result. Synchronous active-low reset sets both counts
// to 128 and restarts the grid; the store is not cleared, each grid writes all it reads.
module grid_max_distance_to_land_top #(
    parameter int GRID_MAX = gmdl_pkg::GRID_MAX_DEF,
    localparam int PW = $clog2(GRID_MAX)
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_is_land,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_max_distance,
    output logic       o_no_answer
);
    logic [7:0] r_row_count, r_col_count;
    logic [PW:0] rows, cols;
    logic        cfg_wr, q_valid, q_ready;
    logic [2*PW+1:0] q_item;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr = i_cfg_valid && o_cfg_ready &&
                    (i_cfg_index inside {gmdl_pkg::CFG_ROWS, gmdl_pkg::CFG_COLS});

    // Clamp counts to 1..GRID_MAX
    always_comb begin
        rows = (r_row_count == 8'd0) ? (PW+1)'(1) :
               ({1'b0, r_row_count} > 9'(GRID_MAX)) ? (PW+1)'(GRID_MAX) : (PW+1)'(r_row_count);
        cols = (r_col_count == 8'd0) ? (PW+1)'(1) :
               ({1'b0, r_col_count} > 9'(GRID_MAX)) ? (PW+1)'(GRID_MAX) : (PW+1)'(r_col_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= 8'd128;
            r_col_count <= 8'd128;
        end else if (cfg_wr) begin
            if (i_cfg_index == gmdl_pkg::CFG_ROWS)      r_row_count <= i_cfg_data;
            else if (i_cfg_index == gmdl_pkg::CFG_COLS) r_col_count <= i_cfg_data;
        end
    end

    gmdl_front #(.GRID_MAX(GRID_MAX)) u_front (
        .i_clk, .i_rst_n, .i_restart(cfg_wr), .i_rows(rows), .i_cols(cols),
        .i_valid, .o_ready, .i_is_land,
        .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item)
    );

    gmdl_back #(.GRID_MAX(GRID_MAX)) u_back (
        .i_clk, .i_rst_n, .i_restart(cfg_wr), .i_rows(rows), .i_cols(cols),
        .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .o_valid, .i_ready, .o_max_distance, .o_no_answer
    );

    a_ans_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_no_answer |-> o_max_distance == 8'd0) else $error("nonzero max");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready && !cfg_wr |=> o_valid && $stable(o_max_distance))
        else $error("result dropped");
endmodule

// ----- tb/gmdl_checker.sv -----
// Checker for the grid max-distance-to-land block: watches the register, cell and
// result channels, predicts each grid result and compares it. Depends on gmdl_pkg.
module gmdl_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    input  logic       i_ready,
    input  logic       i_is_land,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_max_distance,
    input  logic       i_no_answer,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_grids_done
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE = gmdl_pkg::GRID_MAX_DEF;

    typedef struct packed {
        logic [7:0] max_distance;
        logic       no_answer;
    } t_grid_result;

    t_grid_result result_q[$];
    logic [7:0]   dist_mem [0:SIDE*SIDE-1];
    logic [7:0]   rows_reg;
    logic [7:0]   cols_reg;
    int           load_r;
    int           load_c;
    bit           land_seen;
    bit           sea_seen;

    function automatic int clamp_count(input logic [7:0] v);
        if (v == 8'd0) return 1;
        if (int'(v) > SIDE) return SIDE;
        return int'(v);
    endfunction

    function automatic logic [7:0] dist_plus_one(input logic [7:0] d);
        return (d == gmdl_pkg::DIST_NONE) ? gmdl_pkg::DIST_NONE : d + 8'd1;
    endfunction

    // Backward raster sweep: relax against down and right neighbors, track the maximum
    task automatic sweep_back(input int rows, input int cols, output logic [7:0] best);
        logic [7:0] d;
        logic [7:0] t;
        best = 8'd0;
        for (int r = rows - 1; r >= 0; r--) begin
            for (int c = cols - 1; c >= 0; c--) begin
                d = dist_mem[r*SIDE + c];
                if (d != 8'd0) begin
                    if (r + 1 < rows) begin
                        t = dist_plus_one(dist_mem[(r+1)*SIDE + c]);
                        if (t < d) d = t;
                    end
                    if (c + 1 < cols) begin
                        t = dist_plus_one(dist_mem[r*SIDE + c + 1]);
                        if (t < d) d = t;
                    end
                    dist_mem[r*SIDE + c] = d;
                    if (d > best) best = d;
                end
            end
        end
    endtask

    // Forward step for one cell; on the last cell of the grid queue the result
    task automatic take_cell(input logic land);
        int           rows;
        int           cols;
        int           r;
        int           c;
        logic [7:0]   d;
        logic [7:0]   t;
        logic [7:0]   best;
        t_grid_result res;
        rows = clamp_count(rows_reg);
        cols = clamp_count(cols_reg);
        r = (load_r >= rows) ? rows - 1 : load_r;
        c = (load_c >= cols) ? cols - 1 : load_c;
        if (land) begin
            land_seen = 1'b1;
            d = 8'd0;
        end else begin
            sea_seen = 1'b1;
            d = gmdl_pkg::DIST_NONE;
            if (r > 0) begin
                t = dist_plus_one(dist_mem[(r-1)*SIDE + c]);
                if (t < d) d = t;
            end
            if (c > 0) begin
                t = dist_plus_one(dist_mem[r*SIDE + c - 1]);
                if (t < d) d = t;
            end
        end
        dist_mem[r*SIDE + c] = d;
        if (c + 1 < cols) begin
            load_c = c + 1;
            load_r = r;
        end else begin
            load_c = 0;
            if (r + 1 < rows) begin
                load_r = r + 1;
            end else begin
                sweep_back(rows, cols, best);
                res.no_answer    = !(land_seen && sea_seen);
                res.max_distance = res.no_answer ? 8'd0 : best;
                result_q.push_back(res);
                load_r = 0;
                land_seen = 1'b0;
                sea_seen = 1'b0;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_grid_result want;
        if (!i_rst_n) begin
            rows_reg     = 8'd128;
            cols_reg     = 8'd128;
            load_r       = 0;
            load_c       = 0;
            land_seen    = 1'b0;
            sea_seen     = 1'b0;
            result_q.delete();
            o_fail_count <= 0;
            o_grids_done <= 0;
        end else begin
            // compare first: a result leaving now belongs to an earlier grid
            if (i_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: result transfer with none expected: dist %0d flag %0b",
                                 $realtime, i_max_distance, i_no_answer);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = result_q.pop_front();
                    o_grids_done <= o_grids_done + 1;
                    if (want.max_distance !== i_max_distance ||
                        want.no_answer !== i_no_answer) begin
                        if (o_fail_count < 10)
                            $display("%0t: max_distance exp %0d got %0d, no_answer exp %0b got %0b",
                                     $realtime, want.max_distance, i_max_distance,
                                     want.no_answer, i_no_answer);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            // a write to a known register restarts the grid; other indexes do nothing
            if (i_cfg_valid && i_cfg_ready &&
                (i_cfg_index inside {gmdl_pkg::CFG_ROWS, gmdl_pkg::CFG_COLS})) begin
                if (i_cfg_index == gmdl_pkg::CFG_ROWS) rows_reg = i_cfg_data;
                else cols_reg = i_cfg_data;
                load_r = 0;
                load_c = 0;
                land_seen = 1'b0;
                sea_seen = 1'b0;
            end
            if (i_valid && i_ready) take_cell(i_is_land);
        end
        o_pending <= result_q.size();
    end
endmodule

// ----- tb/grid_max_distance_to_land_top_tb.sv -----
// Testbench top for grid_max_distance_to_land_top: drives grids and register writes
// under several idle/stall mixes. Depends on gmdl_pkg and tb/gmdl_checker.sv.
module grid_max_distance_to_land_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 3_000_000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_index = gmdl_pkg::CFG_ROWS;
    logic [7:0] i_cfg_data = 8'd0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic       i_is_land = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_max_distance;
    logic       o_no_answer;

    int fail_count;
    int pending;
    int grids_done;
    int cycles = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int cells_sent = 0;
    int cur_rows = 128;
    int cur_cols = 128;

    grid_max_distance_to_land_top i_dut (.*);

    gmdl_checker i_checker (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_valid, .i_ready(o_ready), .i_is_land,
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_max_distance(o_max_distance), .i_no_answer(o_no_answer),
        .o_fail_count(fail_count), .o_pending(pending), .o_grids_done(grids_done)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver backpressure
    always @(posedge i_clk)
        i_ready <= ($urandom_range(99) >= stall_pct);

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("grid_max_distance_to_land_top: mismatch");
            $finish;
        end
    end

    function automatic int eff_count(input logic [7:0] v);
        if (v == 8'd0) return 1;
        if (v > 8'd128) return 128;
        return int'(v);
    endfunction

    // Drain results, then give the backward pass time to finish before the write
    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        while (pending != 0) @(posedge i_clk);
        repeat (2*cur_rows*cur_cols + 20) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == gmdl_pkg::CFG_ROWS) cur_rows = eff_count(val);
        else if (idx == gmdl_pkg::CFG_COLS) cur_cols = eff_count(val);
    endtask

    task automatic send_cell(input logic land);
        if ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_is_land <= land;
        do @(posedge i_clk); while (!o_ready);
        cells_sent++;
    endtask

    task automatic end_burst();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random grid of the given register values, cut short if asked; land_pct sets land density
    task automatic send_grid(input logic [7:0] rv, input logic [7:0] cv,
                             input int land_pct, input bit cut_short);
        int total;
        write_reg(gmdl_pkg::CFG_ROWS, rv);
        write_reg(gmdl_pkg::CFG_COLS, cv);
        total = cur_rows * cur_cols;
        if (cut_short && total > 1) total = $urandom_range(total - 1, 1);
        for (int k = 0; k < total; k++) send_cell($urandom_range(99) < land_pct);
        end_burst();
    endtask

    function automatic logic [7:0] pick_size();
        case ($urandom_range(19))
            0:       return 8'd0;
            1:       return 8'($urandom_range(255, 129));
            2:       return 8'($urandom_range(24, 9));
            default: return 8'($urandom_range(8, 1));
        endcase
    endfunction

    function automatic int pick_density();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 100;
            2:       return 3;
            3:       return 90;
            default: return $urandom_range(60, 10);
        endcase
    endfunction

    initial begin
        logic [7:0] rv;
        logic [7:0] cv;
        int         cells_goal;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed small cases: single cells, lines, out-of-range sizes, dropped grid
        send_grid(8'd1, 8'd1, 100, 0);
        send_grid(8'd1, 8'd1, 0, 0);
        write_reg(gmdl_pkg::CFG_ROWS, 8'd1);
        write_reg(gmdl_pkg::CFG_COLS, 8'd2);
        send_cell(1'b0); send_cell(1'b1); end_burst();
        write_reg(gmdl_pkg::CFG_ROWS, 8'd3);
        write_reg(gmdl_pkg::CFG_COLS, 8'd1);
        write_reg(8'd2, 8'd7);   // unknown index: no effect, no restart
        send_cell(1'b1); send_cell(1'b0); send_cell(1'b0); end_burst();
        send_grid(8'd0, 8'd0, 50, 0);
        send_grid(8'd255, 8'd0, 0, 0);
        write_reg(gmdl_pkg::CFG_ROWS, 8'd0);
        write_reg(gmdl_pkg::CFG_COLS, 8'd128);
        for (int k = 0; k < 128; k++) send_cell(k == 127);
        end_burst();
        write_reg(gmdl_pkg::CFG_ROWS, 8'd2);
        write_reg(gmdl_pkg::CFG_COLS, 8'd2);
        send_cell(1'b1); send_cell(1'b0); end_burst();   // drop this partial grid
        send_grid(8'd2, 8'd2, 50, 0);

        // Random grids over idle phases; no-idle phase first
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 49; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 49; end
                default: begin gap_pct = 7; stall_pct = 7; end
            endcase
            cells_goal = cells_sent + 200;
            while (cells_sent < cells_goal) begin
                rv = pick_size();
                cv = pick_size();
                // keep each grid small so the run stays near its cell budget
                if (eff_count(rv) * eff_count(cv) > 256) cv = 8'($urandom_range(2, 0));
                send_grid(rv, cv, pick_density(), $urandom_range(15) == 0);
                // now and then, hold off until the block has handed back everything
                if ($urandom_range(5) == 0) while (pending != 0) @(posedge i_clk);
            end
        end

        while (pending != 0) @(posedge i_clk);
        repeat (2*cur_rows*cur_cols + 50) @(posedge i_clk);
        $display("Covered %0d cells in %0d checked grids, sizes 1..128 incl. out-of-range",
                 cells_sent, grids_done);
        $display("register values, four idle/stall mixes, dropped partial grids.");
        if (fail_count == 0) begin
            $display("grid_max_distance_to_land_top: match");
        end else begin
            $display("grid_max_distance_to_land_top: mismatch");
        end
        $finish;
    end
endmodule
